// ===== rtl/core/assert_macros.svh =====
// assertion helpers, compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequence holds in the cycle after the trigger
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/core/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg
// Shared constants and types of the diffusion-reaction stencil step.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

  localparam int unsigned MAX_PLANE_DEF = 1024;
  localparam int unsigned MAX_CELLS_DEF = 1048576;

  localparam int unsigned LEN_W  = 11;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned DATA_W = 32;

  // register indexes on the config port
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_X_LEN     = 3'd1;
  localparam logic [2:0] REG_Y_LEN     = 3'd2;
  localparam logic [2:0] REG_Z_LEN     = 3'd3;
  localparam logic [2:0] REG_DIFF_GAIN = 3'd4;
  localparam logic [2:0] REG_TIME_STEP = 3'd5;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd8;

  // item command codes
  localparam logic CMD_CELL  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic              neumann;
    logic              ghost;
    logic [DATA_W-1:0] reac;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/drs_ram.sv =====
// ----------------------------------------------------------------------------
// drs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 3073
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/diffusion_reaction_stencil_step.sv =====
// ----------------------------------------------------------------------------
// diffusion_reaction_stencil_step
// An item that causes no result returns to idle after admission. One that emits
// a result reads itself and, unless it is a ghost or disabled, its six neighbours
// on the single plane-ring read port; a radix-4 divider gives the relative change
// unless the old value is zero. A plane that overflows the ring runs it for the y cut.
// Synchronous active-low reset clears counters, running max and out_valid and loads config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module diffusion_reaction_stencil_step #(
  parameter int unsigned MAX_PLANE = drs_pkg::MAX_PLANE_DEF,
  parameter int unsigned MAX_CELLS = drs_pkg::MAX_CELLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic        in_sweep_start,
  input  wire logic [31:0] in_cell_conc,
  input  wire logic [31:0] in_cell_reac,
  input  wire logic        in_ghost_flag,
  input  wire logic        in_neumann_flag,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_new_conc,
  output logic [31:0]      out_max_rel_change,
  output logic             out_last_cell,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

`include "assert_macros.svh"

  localparam int unsigned RING = 3 * MAX_PLANE + 1;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned CW   = $clog2(MAX_CELLS + 1);
  localparam int unsigned PW   = $clog2(MAX_PLANE + 1);
  localparam int unsigned SW   = ((CW > PW) ? CW : PW) + 2;
  localparam int unsigned SIDE_W = $bits(drs_pkg::side_t);
  localparam logic [4:0] DV_STEPS = 5'd24;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GEO  = 4'd1;
  localparam logic [3:0] S_GEO2 = 4'd2;
  localparam logic [3:0] S_GDIV = 4'd3;
  localparam logic [3:0] S_GMUL = 4'd4;
  localparam logic [3:0] S_ADM  = 4'd5;
  localparam logic [3:0] S_RD0  = 4'd6;
  localparam logic [3:0] S_RD1  = 4'd7;
  localparam logic [3:0] S_RD2  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_SUM  = 4'd10;
  localparam logic [3:0] S_REL  = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  // neighbour codes, self first
  localparam logic [2:0] NB_SELF = 3'd0;
  localparam logic [2:0] NB_XM   = 3'd1;
  localparam logic [2:0] NB_XP   = 3'd2;
  localparam logic [2:0] NB_YM   = 3'd3;
  localparam logic [2:0] NB_YP   = 3'd4;
  localparam logic [2:0] NB_ZM   = 3'd5;
  localparam logic [2:0] NB_ZP   = 3'd6;

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] s, input logic [PW-1:0] d);
    logic [AW:0] t;
    t = {1'b0, s} + (AW+1)'(d);
    if (t >= (AW+1)'(RING)) t = t - (AW+1)'(RING);
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_sub(input logic [AW-1:0] s, input logic [PW-1:0] d);
    logic [AW:0] t;
    t = {1'b0, s} + (AW+1)'(RING) - (AW+1)'(d);
    if (t >= (AW+1)'(RING)) t = t - (AW+1)'(RING);
    return t[AW-1:0];
  endfunction

  // configuration registers
  logic        enable_r;
  logic [10:0] x_len_r, y_len_r, z_len_r;
  logic [23:0] diff_gain_r;
  logic [31:0] time_step_r;

  // control
  logic [3:0]    state_r;
  logic [CW-1:0] in_cnt_r, out_cnt_r;
  logic [AW-1:0] in_slot_r, out_slot_r;
  logic [31:0]   max_r;
  logic [2:0]    nb_r;
  logic [4:0]    dv_cnt_r;
  logic          out_valid_r;

  // latched item
  logic        icmd_r, istart_r, ighost_r, ineu_r;
  logic [31:0] iconc_r, ireac_r;

  // geometry
  logic [10:0]   geo_x_r, geo_y_r;
  logic [21:0]   xy_r, tot_xy_r;
  logic [32:0]   tot_r;
  logic [PW-1:0] geo_p_r;

  // stencil datapath
  logic [SW-1:0]       m_r;
  logic [AW-1:0]       m_slot_r;
  logic                valid_r, nbok_r, neu_m_r, ghost_r;
  logic [31:0]         raw_m_r, raw_self_r, p_self_r, reac_r, new_r;
  logic [34:0]         sum_r;
  logic signed [61:0]  prod_d_r;
  logic signed [64:0]  prod_r_r;

  // divider
  logic [31:0] dv_rem_r, dv_den_r;
  logic [47:0] dv_quo_r;
  logic [31:0] dv_rem_n;
  logic [47:0] dv_quo_n;

  // output register
  logic [31:0] out_new_r, out_max_r;
  logic        out_last_r;

  // memories
  logic                  ram_we;
  logic [AW-1:0]         raw_raddr, side_raddr;
  logic [31:0]           raw_rdata;
  logic [SIDE_W-1:0]     side_rdata_w;
  drs_pkg::side_t        side_rdata, side_wdata;

  // ---------------------------------------------------------------------------
  // config port
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      drs_pkg::REG_ENABLE:    prdata = {31'b0, enable_r};
      drs_pkg::REG_X_LEN:     prdata = {21'b0, x_len_r};
      drs_pkg::REG_Y_LEN:     prdata = {21'b0, y_len_r};
      drs_pkg::REG_Z_LEN:     prdata = {21'b0, z_len_r};
      drs_pkg::REG_DIFF_GAIN: prdata = {8'b0, diff_gain_r};
      drs_pkg::REG_TIME_STEP: prdata = time_step_r;
      default:                prdata = 32'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // geometry clamps
  // ---------------------------------------------------------------------------
  logic [10:0] x_nz, y_eff, x_eff;
  always_comb begin
    x_nz  = (x_len_r == 11'd0) ? 11'd1 : x_len_r;
    y_eff = (y_len_r == 11'd0) ? 11'd1 : y_len_r;
    x_eff = ({21'b0, x_nz} > 32'(MAX_PLANE)) ? 11'(MAX_PLANE) : x_nz;
  end

  // ---------------------------------------------------------------------------
  // admission of one item
  // ---------------------------------------------------------------------------
  logic          adm_clr, adm_take, adm_emit;
  logic [CW-1:0] adm_in_c, adm_out_c, adm_in_n;
  logic [AW-1:0] adm_in_slot, adm_out_slot;

  always_comb begin
    adm_clr      = (icmd_r == drs_pkg::CMD_CELL) && istart_r;
    adm_in_c     = adm_clr ? '0 : in_cnt_r;
    adm_out_c    = adm_clr ? '0 : out_cnt_r;
    adm_in_slot  = adm_clr ? '0 : in_slot_r;
    adm_out_slot = adm_clr ? '0 : out_slot_r;
    adm_take     = (icmd_r == drs_pkg::CMD_CELL) && (adm_in_c < CW'(MAX_CELLS));
    adm_in_n     = adm_in_c + CW'(1);
    if (adm_take) begin
      adm_emit = (SW'(adm_in_n) - SW'(adm_out_c)) > SW'({geo_p_r, 1'b0});
    end else begin
      adm_emit = adm_out_c < adm_in_c;
    end
  end

  // ---------------------------------------------------------------------------
  // neighbour address generation
  // ---------------------------------------------------------------------------
  logic          nb_neg, nb_valid;
  logic [PW-1:0] nb_d;
  logic [SW-1:0] nb_k, nb_c, nb_m;
  logic [AW-1:0] nb_slot;

  always_comb begin
    unique case (nb_r)
      NB_XM:   begin nb_neg = 1'b1; nb_d = PW'(1);       end
      NB_XP:   begin nb_neg = 1'b0; nb_d = PW'(1);       end
      NB_YM:   begin nb_neg = 1'b1; nb_d = PW'(geo_x_r); end
      NB_YP:   begin nb_neg = 1'b0; nb_d = PW'(geo_x_r); end
      NB_ZM:   begin nb_neg = 1'b1; nb_d = geo_p_r;      end
      NB_ZP:   begin nb_neg = 1'b0; nb_d = geo_p_r;      end
      default: begin nb_neg = 1'b0; nb_d = '0;           end
    endcase
    nb_k     = SW'(out_cnt_r);
    nb_c     = SW'(in_cnt_r);
    nb_m     = nb_neg ? (nb_k - SW'(nb_d)) : (nb_k + SW'(nb_d));
    nb_valid = nb_neg ? (nb_k >= SW'(nb_d)) : (nb_m < nb_c);
    nb_slot  = nb_neg ? slot_sub(out_slot_r, nb_d) : slot_add(out_slot_r, nb_d);
  end

  assign side_raddr = nb_slot;
  assign raw_raddr  = (state_r == S_RD1) ? slot_add(m_slot_r, geo_p_r) : nb_slot;
  assign ram_we     = (state_r == S_ADM) && adm_take;
  assign side_wdata = '{neumann: ineu_r, ghost: ighost_r, reac: ireac_r};
  assign side_rdata = drs_pkg::side_t'(side_rdata_w);

  drs_ram #(.WIDTH(32), .DEPTH(RING)) u_raw_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (adm_in_slot),
    .wdata (iconc_r),
    .raddr (raw_raddr),
    .rdata (raw_rdata)
  );

  drs_ram #(.WIDTH(SIDE_W), .DEPTH(RING)) u_side_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (adm_in_slot),
    .wdata (side_wdata),
    .raddr (side_raddr),
    .rdata (side_rdata_w)
  );

  // ---------------------------------------------------------------------------
  // arithmetic
  // ---------------------------------------------------------------------------
  logic [31:0]        p_j;
  logic signed [36:0] lap;
  logic signed [61:0] rnd_d;
  logic signed [64:0] rnd_r;
  logic signed [65:0] t_sum;
  logic [31:0]        t_clamp, abs_d, rel;

  always_comb begin
    p_j   = (neu_m_r && nbok_r) ? raw_rdata : raw_m_r;
    lap   = $signed({2'b0, sum_r}) - $signed({3'b0, p_self_r, 2'b0})
          - $signed({4'b0, p_self_r, 1'b0});
    // round half up, arithmetic shift floors
    rnd_d = (prod_d_r + (62'sd1 <<< 23)) >>> 24;
    rnd_r = (prod_r_r + (65'sd1 <<< 15)) >>> 16;
    t_sum = $signed({34'b0, p_self_r}) + {{4{rnd_d[61]}}, rnd_d} + {rnd_r[64], rnd_r};
    if (t_sum[65])             t_clamp = 32'd0;
    else if (|t_sum[64:32])    t_clamp = 32'hFFFF_FFFF;
    else                       t_clamp = t_sum[31:0];
    abs_d = (new_r > p_self_r) ? (new_r - p_self_r) : (p_self_r - new_r);
    rel   = (|dv_quo_r[47:32]) ? 32'hFFFF_FFFF : dv_quo_r[31:0];
  end

  // restoring divider, two quotient bits per cycle
  always_comb begin
    logic [32:0] t;
    dv_rem_n = dv_rem_r;
    dv_quo_n = dv_quo_r;
    for (int i = 0; i < 2; i++) begin
      t        = {dv_rem_n, dv_quo_n[47]};
      dv_quo_n = {dv_quo_n[46:0], 1'b0};
      if (t >= {1'b0, dv_den_r}) begin
        t           = t - {1'b0, dv_den_r};
        dv_quo_n[0] = 1'b1;
      end
      dv_rem_n = t[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      x_len_r     <= drs_pkg::LEN_RESET;
      y_len_r     <= drs_pkg::LEN_RESET;
      z_len_r     <= drs_pkg::LEN_RESET;
      diff_gain_r <= '0;
      time_step_r <= '0;
      state_r     <= S_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      in_slot_r   <= '0;
      out_slot_r  <= '0;
      max_r       <= '0;
      nb_r        <= NB_SELF;
      dv_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          drs_pkg::REG_ENABLE:    enable_r    <= pwdata[0];
          drs_pkg::REG_X_LEN:     x_len_r     <= pwdata[10:0];
          drs_pkg::REG_Y_LEN:     y_len_r     <= pwdata[10:0];
          drs_pkg::REG_Z_LEN:     z_len_r     <= pwdata[10:0];
          drs_pkg::REG_DIFF_GAIN: diff_gain_r <= pwdata[23:0];
          drs_pkg::REG_TIME_STEP: time_step_r <= pwdata;
          default: ;
        endcase
      end

      // in S_OUT the load below decides the flag
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;

      if (dv_cnt_r != 5'd0) begin
        dv_rem_r <= dv_rem_n;
        dv_quo_r <= dv_quo_n;
        dv_cnt_r <= dv_cnt_r - 5'd1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            icmd_r   <= in_cmd;
            istart_r <= in_sweep_start;
            iconc_r  <= in_cell_conc;
            ireac_r  <= in_cell_reac;
            ighost_r <= in_ghost_flag;
            ineu_r   <= in_neumann_flag;
            state_r  <= S_GEO;
          end
        end
        S_GEO: begin
          geo_x_r  <= x_eff;
          geo_y_r  <= y_eff;
          xy_r     <= x_eff * y_eff;
          tot_xy_r <= x_len_r * y_len_r;
          state_r  <= S_GEO2;
        end
        S_GEO2: begin
          tot_r <= tot_xy_r * z_len_r;
          if ({10'b0, xy_r} > 32'(MAX_PLANE)) begin
            // plane too large: y becomes MAX_PLANE / x
            dv_rem_r <= '0;
            dv_quo_r <= 48'(MAX_PLANE);
            dv_den_r <= {21'b0, geo_x_r};
            dv_cnt_r <= DV_STEPS;
            state_r  <= S_GDIV;
          end else begin
            geo_p_r <= PW'(xy_r);
            state_r <= S_ADM;
          end
        end
        S_GDIV: begin
          if (dv_cnt_r == 5'd0) begin
            geo_y_r <= dv_quo_r[10:0];
            state_r <= S_GMUL;
          end
        end
        S_GMUL: begin
          geo_p_r <= PW'(geo_x_r * geo_y_r);
          state_r <= S_ADM;
        end
        S_ADM: begin
          if (adm_clr) max_r <= '0;
          out_cnt_r  <= adm_out_c;
          out_slot_r <= adm_out_slot;
          if (adm_take) begin
            in_cnt_r  <= adm_in_n;
            in_slot_r <= slot_add(adm_in_slot, PW'(1));
          end else begin
            in_cnt_r  <= adm_in_c;
            in_slot_r <= adm_in_slot;
          end
          nb_r    <= NB_SELF;
          state_r <= adm_emit ? S_RD0 : S_IDLE;
        end
        S_RD0: begin
          m_r      <= nb_m;
          m_slot_r <= nb_slot;
          valid_r  <= nb_valid;
          state_r  <= S_RD1;
        end
        S_RD1: begin
          raw_m_r <= raw_rdata;
          neu_m_r <= side_rdata.neumann;
          nbok_r  <= (m_r + SW'(geo_p_r)) < nb_c;
          if (nb_r == NB_SELF) begin
            ghost_r    <= side_rdata.ghost;
            reac_r     <= side_rdata.reac;
            raw_self_r <= raw_rdata;
          end
          state_r <= S_RD2;
        end
        S_RD2: begin
          if (nb_r == NB_SELF) begin
            p_self_r <= p_j;
            sum_r    <= '0;
            if (!enable_r) begin
              new_r   <= raw_self_r;
              state_r <= S_OUT;
            end else if (ghost_r) begin
              new_r   <= p_j;
              state_r <= S_OUT;
            end else begin
              nb_r    <= NB_XM;
              state_r <= S_RD0;
            end
          end else begin
            sum_r <= sum_r + {3'b0, (valid_r ? p_j : p_self_r)};
            if (nb_r == NB_ZP) begin
              state_r <= S_MUL;
            end else begin
              nb_r    <= nb_r + 3'd1;
              state_r <= S_RD0;
            end
          end
        end
        S_MUL: begin
          prod_d_r <= $signed({1'b0, diff_gain_r}) * lap;
          prod_r_r <= $signed({1'b0, time_step_r}) * $signed(reac_r);
          state_r  <= S_SUM;
        end
        S_SUM: begin
          new_r   <= t_clamp;
          state_r <= S_REL;
        end
        S_REL: begin
          if (p_self_r == 32'd0) begin
            max_r   <= 32'hFFFF_FFFF;
            state_r <= S_OUT;
          end else begin
            dv_rem_r <= '0;
            dv_quo_r <= {abs_d, 16'b0};
            dv_den_r <= p_self_r;
            dv_cnt_r <= DV_STEPS;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_cnt_r == 5'd0) begin
            if (rel > max_r) max_r <= rel;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_new_r   <= new_r;
            out_max_r   <= max_r;
            out_last_r  <= (tot_r != 33'd0) && ({{(33-CW){1'b0}}, out_cnt_r} == tot_r - 33'd1);
            out_valid_r <= 1'b1;
            out_cnt_r   <= out_cnt_r + CW'(1);
            out_slot_r  <= slot_add(out_slot_r, PW'(1));
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_new_conc       = out_new_r;
  assign out_max_rel_change = out_max_r;
  assign out_last_cell      = out_last_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_out_behind_in, out_cnt_r <= in_cnt_r, "emitted more cells than received")
  `ASSERT_ALWAYS(a_in_cnt_cap, in_cnt_r <= CW'(MAX_CELLS), "input counter past capacity")
  `ASSERT_ALWAYS(a_raddr_range, {1'b0, raw_raddr} < (AW+1)'(RING), "ring read address out of range")
  `ASSERT_NEXT(a_out_load, (state_r == S_OUT) && (!out_valid_r || out_ready), out_valid_r && (state_r == S_IDLE), "result not registered")

endmodule

`default_nettype wire

// ===== bench/diffusion_reaction_stencil_step_tb.sv =====
// ----------------------------------------------------------------------------
// diffusion_reaction_stencil_step_tb
// Streams cells and drain ticks through the stencil step under random gaps and
// stalls, predicts every result with its own fixed-point stencil model and
// compares each one field by field, across several grid and gain settings.
// ----------------------------------------------------------------------------
`default_nettype none

module diffusion_reaction_stencil_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = 3 * drs_pkg::MAX_PLANE_DEF + 1;

  typedef struct packed {
    logic        cmd;
    logic        sweep_start;
    logic [31:0] conc;
    logic [31:0] reac;
    logic        ghost;
    logic        neumann;
  } cell_item_t;

  typedef struct packed {
    logic [31:0] new_conc;
    logic [31:0] max_rel;
    logic        last_cell;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic in_sweep_start = 1'b0;
  logic [31:0] in_cell_conc = '0;
  logic [31:0] in_cell_reac = '0;
  logic in_ghost_flag = 1'b0;
  logic in_neumann_flag = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_new_conc;
  logic [31:0] out_max_rel_change;
  logic out_last_cell;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  diffusion_reaction_stencil_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_sweep_start(in_sweep_start), .in_cell_conc(in_cell_conc),
    .in_cell_reac(in_cell_reac), .in_ghost_flag(in_ghost_flag),
    .in_neumann_flag(in_neumann_flag),
    .out_valid(out_valid), .out_ready(out_ready), .out_new_conc(out_new_conc),
    .out_max_rel_change(out_max_rel_change), .out_last_cell(out_last_cell),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // stencil predictor state
  logic [31:0] raw_ring [RING_DEPTH];
  logic [33:0] side_ring [RING_DEPTH];
  int unsigned cells_in, cells_out;
  logic [31:0] peak_rel;
  logic        en_r;
  logic [10:0] xl_r, yl_r, zl_r;
  logic [23:0] gain_r;
  logic [31:0] dt_r;
  int unsigned eff_x, eff_p;

  cell_result_t expected_q[$];
  cell_item_t   pending_q[$];
  int errors = 0;
  bit hold_out = 0;
  int unsigned hold_cycles = 0;

  function automatic longint rnd_shift(longint v, int s);
    longint y;
    y = v + (longint'(1) <<< (s - 1));
    return y >>> s;  // arithmetic shift is floor
  endfunction

  function automatic logic [31:0] pre_value(int unsigned m, int unsigned c);
    if (side_ring[m % RING_DEPTH][33] && longint'(m) + eff_p < c)
      return raw_ring[(m + eff_p) % RING_DEPTH];
    return raw_ring[m % RING_DEPTH];
  endfunction

  function automatic cell_result_t emit_cell();
    cell_result_t r;
    int unsigned k;
    logic [33:0] sd;
    logic [31:0] p, nv, rel;
    longint offs [6];
    longint sum, m, lap, t, rv, d, q;
    k = cells_out;
    sd = side_ring[k % RING_DEPTH];
    p = pre_value(k, cells_in);
    if (!en_r) begin
      nv = raw_ring[k % RING_DEPTH];
    end else if (sd[32]) begin
      nv = p;
    end else begin
      offs = '{-1, 1, -longint'(eff_x), longint'(eff_x), -longint'(eff_p), longint'(eff_p)};
      sum = 0;
      for (int i = 0; i < 6; i++) begin
        m = longint'(k) + offs[i];
        if (m >= 0 && m < longint'(cells_in)) sum += pre_value(int'(m), cells_in);
        else sum += p;
      end
      lap = sum - 6 * longint'(p);
      rv = longint'($signed(sd[31:0]));
      t = longint'(p) + rnd_shift(longint'(gain_r) * lap, 24)
          + rnd_shift(longint'(dt_r) * rv, 16);
      if (t < 0) t = 0;
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      nv = t[31:0];
      if (p == 0) begin
        rel = '1;
      end else begin
        d = (nv > p) ? longint'(nv - p) : longint'(p - nv);
        q = (d <<< 16) / longint'(p);
        rel = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
      end
      if (rel > peak_rel) peak_rel = rel;
    end
    r.new_conc = nv;
    r.max_rel = peak_rel;
    r.last_cell = (longint'(k) == longint'(xl_r) * yl_r * zl_r - 1);
    cells_out = k + 1;
    return r;
  endfunction

  function automatic void predict_item(cell_item_t it);
    int unsigned x, y;
    x = (xl_r == 0) ? 1 : xl_r;
    y = (yl_r == 0) ? 1 : yl_r;
    if (x > drs_pkg::MAX_PLANE_DEF) x = drs_pkg::MAX_PLANE_DEF;
    if (x * y > drs_pkg::MAX_PLANE_DEF) y = drs_pkg::MAX_PLANE_DEF / x;
    eff_x = x;
    eff_p = x * y;
    if (it.cmd == drs_pkg::CMD_CELL && it.sweep_start) begin
      cells_in = 0;
      cells_out = 0;
      peak_rel = 0;
    end
    if (it.cmd == drs_pkg::CMD_CELL && cells_in < drs_pkg::MAX_CELLS_DEF) begin
      raw_ring[cells_in % RING_DEPTH] = it.conc;
      side_ring[cells_in % RING_DEPTH] = {it.neumann, it.ghost, it.reac};
      cells_in++;
      if (cells_in - cells_out > 2 * eff_p) expected_q.push_back(emit_cell());
    end else if (cells_out < cells_in) begin
      expected_q.push_back(emit_cell());
    end
  endfunction

  // capture of the input transfer at the rising edge, used by the driver
  logic in_ready_s = 1'b0;
  always @(posedge clk) in_ready_s <= in_valid && in_ready;

  // driver
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_s) begin
        in_valid <= 1'b0;
        send_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end else if (!in_valid && send_gap > 0) begin
        send_gap--;
      end else if (!in_valid && pending_q.size() > 0) begin
        cell_item_t it;
        it = pending_q.pop_front();
        predict_item(it);
        in_cmd <= it.cmd;
        in_sweep_start <= it.sweep_start;
        in_cell_conc <= it.conc;
        in_cell_reac <= it.reac;
        in_ghost_flag <= it.ghost;
        in_neumann_flag <= it.neumann;
        in_valid <= 1'b1;
      end
    end
  end

  // receiver stalls and monitor
  int unsigned recv_gap = 0;
  always @(negedge clk) begin
    if (hold_out) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      out_ready <= (recv_gap == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: conc %h", out_new_conc);
        errors++;
      end else begin
        cell_result_t e;
        e = expected_q.pop_front();
        if (out_new_conc !== e.new_conc) begin
          $error("new_conc expected %h got %h", e.new_conc, out_new_conc);
          errors++;
        end
        if (out_max_rel_change !== e.max_rel) begin
          $error("max_rel_change expected %h got %h", e.max_rel, out_max_rel_change);
          errors++;
        end
        if (out_last_cell !== e.last_cell) begin
          $error("last_cell expected %b got %b", e.last_cell, out_last_cell);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      drs_pkg::REG_ENABLE:    en_r = val[0];
      drs_pkg::REG_X_LEN:     xl_r = val[10:0];
      drs_pkg::REG_Y_LEN:     yl_r = val[10:0];
      drs_pkg::REG_Z_LEN:     zl_r = val[10:0];
      drs_pkg::REG_DIFF_GAIN: gain_r = val[23:0];
      drs_pkg::REG_TIME_STEP: dt_r = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(bit en, int x, int y, int z, logic [23:0] g, logic [31:0] dt);
    reg_write(drs_pkg::REG_ENABLE, 32'(en));
    reg_write(drs_pkg::REG_X_LEN, 32'(x));
    reg_write(drs_pkg::REG_Y_LEN, 32'(y));
    reg_write(drs_pkg::REG_Z_LEN, 32'(z));
    reg_write(drs_pkg::REG_DIFF_GAIN, 32'(g));
    reg_write(drs_pkg::REG_TIME_STEP, dt);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pending_q.size() > 0 || in_valid || expected_q.size() > 0) && guard < 2_000_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_conc();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 3);
      default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_reac();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  // one sweep with ghost shell (flags randomised for noise percent of cells), followed by drain ticks
  task automatic queue_sweep(int x, int y, int z, int noise);
    cell_item_t it;
    for (int k = 0; k < x * y * z; k++) begin
      int cx, cy, cz;
      cx = k % x;
      cy = (k / x) % y;
      cz = k / (x * y);
      it.cmd = drs_pkg::CMD_CELL;
      it.sweep_start = (k == 0);
      it.conc = rand_conc();
      it.reac = rand_reac();
      it.ghost = (cx == 0 || cx == x - 1 || cy == 0 || cy == y - 1 || cz == 0 || cz == z - 1);
      it.neumann = (cz == 0);
      if ($urandom_range(0, 99) < noise) begin
        it.ghost = $urandom_range(0, 1);
        it.neumann = $urandom_range(0, 1);
      end
      pending_q.push_back(it);
    end
    for (int k = 0; k < 2 * x * y + 2; k++) begin
      it = '0;
      it.cmd = drs_pkg::CMD_DRAIN;
      it.sweep_start = $urandom_range(0, 1);
      it.conc = $urandom();
      it.reac = $urandom();
      pending_q.push_back(it);
    end
  endtask

  initial begin
    cell_item_t it;
    int x, y, z;
    cells_in = 0;
    cells_out = 0;
    peak_rel = 0;
    en_r = 1'b1;
    xl_r = drs_pkg::LEN_RESET;
    yl_r = drs_pkg::LEN_RESET;
    zl_r = drs_pkg::LEN_RESET;
    gain_r = 0;
    dt_r = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: small grid, extremes, drain on empty
    set_grid(1, 3, 3, 3, 24'hFF_FFFF, 32'hFFFF_FFFF);
    it = '0;
    it.cmd = drs_pkg::CMD_DRAIN;
    pending_q.push_back(it);
    queue_sweep(3, 3, 3, 0);
    wait_idle();
    set_grid(1, 3, 3, 3, 24'h20_0000, 32'h0001_0000);
    queue_sweep(3, 3, 3, 40);
    wait_idle();
    // receiver holds off while the sender keeps offering
    set_grid(0, 4, 3, 3, 24'h10_0000, 32'h0000_8000);
    hold_out = 1;
    queue_sweep(4, 3, 3, 0);
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 3000) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_out = 0;
      end
    join_none
    wait_idle();
    // bad geometry: x filling the plane store, y cut, x and y zero
    set_grid(1, 1024, 2, 3, 24'h08_0000, 32'h0000_1000);
    for (int k = 0; k < 40; k++) begin
      it = '0;
      it.cmd = drs_pkg::CMD_CELL;
      it.sweep_start = (k == 0);
      it.conc = rand_conc();
      it.reac = rand_reac();
      it.ghost = $urandom_range(0, 1);
      it.neumann = $urandom_range(0, 1);
      pending_q.push_back(it);
    end
    for (int k = 0; k < 45; k++) begin
      it = '0;
      it.cmd = drs_pkg::CMD_DRAIN;
      pending_q.push_back(it);
    end
    wait_idle();
    set_grid(1, 0, 0, 3, 24'h00_0001, 32'h0000_0001);
    queue_sweep(3, 3, 1, 50);
    wait_idle();

    // random sweeps
    while ($urandom_range(0, 0) == 0) begin
      int total;
      total = 0;
      for (int s = 0; s < 10; s++) begin
        x = $urandom_range(3, 6);
        y = $urandom_range(3, 5);
        z = $urandom_range(3, 4);
        set_grid($urandom_range(0, 7) != 0, x, y, z, $urandom_range(0, 24'hFF_FFFF),
                 ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0002_0000));
        queue_sweep(x, y, z, $urandom_range(0, 20));
        total += x * y * z;
        wait_idle();
        if (total > 1150) break;
      end
      break;
    end
    set_grid(1, 8, 8, 8, 24'h00_0000, 32'h0000_0000);

    wait_idle();
    if (errors == 0 && expected_q.size() == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
